@@ rtl/mtq_pkg.sv @@
// ----------------------------------------------------------------------------
// mtq_pkg
// Shared constants and types of the max tracking queue: store geometry,
// operation codes and status codes.
// ----------------------------------------------------------------------------
package mtq_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CW          = $clog2(STORE_DEPTH + 1);
    localparam int DW          = 64;
    localparam int EW          = 2 * DW;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_EMPTY = 2'd2,
        OP_MAX   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

@@ rtl/mtq_ram.sv @@
// ----------------------------------------------------------------------------
// mtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtq_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mtq_max.sv @@
// ----------------------------------------------------------------------------
// mtq_max
// Shared signed compare unit: returns the larger of two 64-bit words.
// ----------------------------------------------------------------------------
module mtq_max (
    input  logic signed [mtq_pkg::DW-1:0] i_a,
    input  logic signed [mtq_pkg::DW-1:0] i_b,
    output logic signed [mtq_pkg::DW-1:0] o_max
);

    assign o_max = (i_a > i_b) ? i_a : i_b;

endmodule

@@ rtl/max_tracking_queue_core.sv @@
// ----------------------------------------------------------------------------
// max_tracking_queue_core
// FIFO of signed 64-bit words that also reports its current maximum, built
// from two stacks sharing one store and growing towards each other.
//
// Input channel: i_in_valid / o_in_ready with i_opcode and i_value
// (enqueue, dequeue, query empty, query maximum). Output channel:
// o_out_valid / i_out_ready with o_data_out, o_queue_empty and o_status,
// one result word per input word, in order.
// One word is in work at a time. Enqueue, query empty, query maximum and a
// dequeue on an empty queue pass from S_EXEC into the pending result, and
// the next word is taken once that result moves into the output register.
// A dequeue from a non-empty out-stack steps through S_POP_ADR, S_POP_V and
// S_POP_M, skipping S_POP_M when it removes the last out-stack entry.
// When the out-stack is empty the whole in-stack is moved first, each entry
// read in S_XFER_RD and written in S_XFER_WR; each entry moves at most once.
// Reset empties both stacks at once (no clearing pass); the store contents
// are left as they are. A result waits in the output register while the
// receiver stalls, and the block accepts no new word once its next result
// cannot be placed there.
// ----------------------------------------------------------------------------
module max_tracking_queue_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_opcode,
    input  logic signed [mtq_pkg::DW-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [mtq_pkg::DW-1:0] o_data_out,
    output logic                          o_queue_empty,
    output logic [1:0]                    o_status
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EXEC    = 7'b0000010,
        S_XFER_RD = 7'b0000100,
        S_XFER_WR = 7'b0001000,
        S_POP_ADR = 7'b0010000,
        S_POP_V   = 7'b0100000,
        S_POP_M   = 7'b1000000
    } t_state;

    localparam logic [mtq_pkg::CW-1:0] FULL_BASE = mtq_pkg::CW'(mtq_pkg::STORE_DEPTH);

    t_state                        r_state,      n_state;
    t_state                        r_ret,        n_ret;
    mtq_pkg::t_op                  r_op,         n_op;
    logic signed [mtq_pkg::DW-1:0] r_val,        n_val;
    logic [mtq_pkg::CW-1:0]        r_in_top,     n_in_top;
    logic [mtq_pkg::CW-1:0]        r_out_base,   n_out_base;
    logic signed [mtq_pkg::DW-1:0] r_in_max,     n_in_max;
    logic signed [mtq_pkg::DW-1:0] r_out_max,    n_out_max;
    logic signed [mtq_pkg::DW-1:0] r_res_data,   n_res_data;
    mtq_pkg::t_status              r_res_status, n_res_status;
    logic                          r_res_pend,   n_res_pend;
    logic                          r_o_valid,    n_o_valid;
    logic signed [mtq_pkg::DW-1:0] r_o_data,     n_o_data;
    logic                          r_o_empty,    n_o_empty;
    mtq_pkg::t_status              r_o_status,   n_o_status;

    logic                          in_empty;
    logic                          out_empty;
    logic                          full;
    logic                          slot_free;
    logic signed [mtq_pkg::DW-1:0] cmp_a;
    logic signed [mtq_pkg::DW-1:0] cmp_b;
    logic signed [mtq_pkg::DW-1:0] cmp_max;
    logic                          ram_we;
    logic [mtq_pkg::AW-1:0]        ram_waddr;
    logic [mtq_pkg::EW-1:0]        ram_wdata;
    logic [mtq_pkg::AW-1:0]        ram_raddr;
    logic [mtq_pkg::EW-1:0]        ram_rdata;
    logic signed [mtq_pkg::DW-1:0] rd_value;
    logic signed [mtq_pkg::DW-1:0] rd_max;
    logic [mtq_pkg::CW-1:0]        in_top_m1;
    logic [mtq_pkg::CW-1:0]        out_base_m1;
    logic [mtq_pkg::CW-1:0]        out_base_p1;

    mtq_ram #(
        .WIDTH(mtq_pkg::EW),
        .DEPTH(mtq_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    mtq_max u_max (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_max(cmp_max)
    );

    assign in_empty    = (r_in_top == '0);
    assign out_empty   = (r_out_base == FULL_BASE);
    assign full        = (r_in_top >= r_out_base);
    assign slot_free   = !r_o_valid || i_out_ready;
    assign rd_value    = ram_rdata[mtq_pkg::EW-1:mtq_pkg::DW];
    assign rd_max      = ram_rdata[mtq_pkg::DW-1:0];
    assign in_top_m1   = r_in_top - mtq_pkg::CW'(1);
    assign out_base_m1 = r_out_base - mtq_pkg::CW'(1);
    assign out_base_p1 = r_out_base + mtq_pkg::CW'(1);

    assign o_in_ready    = (r_state == S_IDLE) && !r_res_pend;
    assign o_out_valid   = r_o_valid;
    assign o_data_out    = r_o_data;
    assign o_queue_empty = r_o_empty;
    assign o_status      = r_o_status;

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_op         = r_op;
        n_val        = r_val;
        n_in_top     = r_in_top;
        n_out_base   = r_out_base;
        n_in_max     = r_in_max;
        n_out_max    = r_out_max;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_res_pend   = r_res_pend;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_data     = r_o_data;
        n_o_empty    = r_o_empty;
        n_o_status   = r_o_status;
        cmp_a        = r_in_max;
        cmp_b        = r_val;
        ram_we       = 1'b0;
        ram_waddr    = r_in_top[mtq_pkg::AW-1:0];
        ram_wdata    = {r_val, r_val};
        ram_raddr    = in_top_m1[mtq_pkg::AW-1:0];

        // result hand-off to the output register
        if (r_res_pend && slot_free) begin
            n_o_valid  = 1'b1;
            n_o_data   = r_res_data;
            n_o_status = r_res_status;
            n_o_empty  = in_empty && out_empty;
            n_res_pend = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_op    = mtq_pkg::t_op'(i_opcode);
                    n_val   = i_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_data   = '0;
                n_res_status = mtq_pkg::ST_OK;
                n_state      = S_IDLE;
                n_ret        = S_IDLE;
                case (r_op)
                    mtq_pkg::OP_ENQ: begin
                        if (full) begin
                            n_res_status = mtq_pkg::ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {r_val, (in_empty ? r_val : cmp_max)};
                            n_in_max  = in_empty ? r_val : cmp_max;
                            n_in_top  = r_in_top + mtq_pkg::CW'(1);
                        end
                        n_res_pend = 1'b1;
                    end
                    mtq_pkg::OP_DEQ: begin
                        if (in_empty && out_empty) begin
                            n_res_status = mtq_pkg::ST_EMPTY;
                            n_res_pend   = 1'b1;
                        end else if (out_empty) begin
                            n_state = S_XFER_RD;
                        end else begin
                            n_state = S_POP_ADR;
                        end
                    end
                    mtq_pkg::OP_EMPTY: begin
                        n_res_pend = 1'b1;
                    end
                    mtq_pkg::OP_MAX: begin
                        cmp_b = r_out_max;
                        if (in_empty && out_empty) begin
                            n_res_status = mtq_pkg::ST_EMPTY;
                        end else if (in_empty) begin
                            n_res_data = r_out_max;
                        end else if (out_empty) begin
                            n_res_data = r_in_max;
                        end else begin
                            n_res_data = cmp_max;
                        end
                        n_res_pend = 1'b1;
                    end
                    default: begin
                        n_res_pend = 1'b1;
                    end
                endcase
            end
            S_XFER_RD: begin
                // read address is the in-stack top by default
                n_state = S_XFER_WR;
            end
            S_XFER_WR: begin
                cmp_a      = r_out_max;
                cmp_b      = rd_value;
                ram_we     = 1'b1;
                ram_waddr  = out_base_m1[mtq_pkg::AW-1:0];
                ram_wdata  = {rd_value, (out_empty ? rd_value : cmp_max)};
                n_out_max  = out_empty ? rd_value : cmp_max;
                n_out_base = out_base_m1;
                n_in_top   = in_top_m1;
                n_state    = (in_top_m1 == '0) ? S_POP_ADR : S_XFER_RD;
            end
            S_POP_ADR: begin
                ram_raddr = r_out_base[mtq_pkg::AW-1:0];
                n_state   = S_POP_V;
            end
            S_POP_V: begin
                ram_raddr    = out_base_p1[mtq_pkg::AW-1:0];
                n_res_data   = rd_value;
                n_res_status = mtq_pkg::ST_OK;
                n_out_base   = out_base_p1;
                if (out_base_p1 == FULL_BASE) begin
                    n_res_pend = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_POP_M;
                end
            end
            S_POP_M: begin
                n_out_max  = rd_max;
                n_res_pend = 1'b1;
                n_state    = r_ret;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_in_top   <= '0;
            r_out_base <= FULL_BASE;
            r_res_pend <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_in_top   <= n_in_top;
            r_out_base <= n_out_base;
            r_res_pend <= n_res_pend;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_val        <= n_val;
        r_in_max     <= n_in_max;
        r_out_max    <= n_out_max;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_o_data     <= n_o_data;
        r_o_empty    <= n_o_empty;
        r_o_status   <= n_o_status;
    end

    // stacks never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_top <= r_out_base)
        else $error("in-stack runs into out-stack");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_base <= FULL_BASE)
        else $error("out-stack base out of range");

    // error results carry zero data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_status != mtq_pkg::ST_OK)) |-> (r_o_data == '0))
        else $error("nonzero data on error result");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("word accepted while busy");

endmodule
